### rtl/rti_pkg.sv
// Package for the ray/triangle intersection block: payload types, queue entry,
// divider stage record and widths. No dependencies.
`timescale 1ns / 1ps

package rti_pkg;

	localparam int MW   = 53;      // magnitude of divisor and barycentric numerators
	localparam int NTW  = 61;      // magnitude of the distance numerator
	localparam int RW   = MW + 16; // divider remainder
	localparam int QW   = 16;      // quotient bits per lane
	localparam int QD   = 8;       // queue depth, covers the front latency
	localparam int QAW  = $clog2(QD);
	localparam int CNTW = $clog2(QD + 1);
	localparam logic [16:0] ONE_Q15 = 17'd32768;

	typedef enum logic [1:0] {
		REG_VERTEX_A = 2'd0,
		REG_VERTEX_B = 2'd1,
		REG_VERTEX_C = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [15:0]        t_max;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] t_out;
		logic [15:0] bary_0;
		logic [15:0] bary_1;
		logic [15:0] bary_2;
	} res_t;

	typedef struct packed {
		logic           kind;
		logic [15:0]    t_max;
		logic           ok;
		logic [MW-1:0]  dv;
		logic [MW-1:0]  n1;
		logic [MW-1:0]  n2;
		logic [NTW-1:0] nt;
	} qent_t;

	typedef struct packed {
		logic          kind;
		logic [15:0]   t_max;
		logic          ok;
		logic [MW-1:0] dv;
		logic [RW-1:0] r_t;
		logic [RW-1:0] r_1;
		logic [RW-1:0] r_2;
		logic [QW-1:0] q_t;
		logic [QW-1:0] q_1;
		logic [QW-1:0] q_2;
	} div_t;

	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

endpackage

### rtl/rti_front.sv
// Front part: takes rays, forms edges, cross and dot products, classifies the
// hit conditions and pushes one entry per ray. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ray_valid,
	output logic           ray_stall,
	input  rti_pkg::ray_t  ray,
	input  logic [47:0]    vertex_a,
	input  logic [47:0]    vertex_b,
	input  logic [47:0]    vertex_c,
	input  logic           pop,
	output logic           push,
	output rti_pkg::qent_t push_data
);
	import rti_pkg::*;

	function automatic logic signed [34:0] xd(input logic signed [16:0] p, q, r, u);
		logic signed [33:0] m0;
		logic signed [33:0] m1;
		m0 = p * q;
		m1 = r * u;
		return 35'(m0) - 35'(m1);
	endfunction

	function automatic logic signed [51:0] mp(input logic signed [34:0] p,
		input logic signed [16:0] q);
		logic signed [51:0] m;
		m = p * q;
		return m;
	endfunction

	logic signed [15:0] va [3];
	logic signed [15:0] vb [3];
	logic signed [15:0] vc [3];
	logic signed [15:0] org [3];
	logic signed [15:0] dir [3];

	logic               acc;
	logic [CNTW-1:0]    cnt_q;
	logic [4:0]         v_q;
	logic [15:0]        tmax_s1, tmax_s2, tmax_s3, tmax_s4, tmax_s5;
	logic               kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic signed [16:0] e1_s1 [3];
	logic signed [16:0] e2_s1 [3];
	logic signed [16:0] s_s1 [3];
	logic signed [16:0] d_s1 [3];
	logic signed [16:0] e1_s2 [3];
	logic signed [16:0] e2_s2 [3];
	logic signed [16:0] s_s2 [3];
	logic signed [16:0] d_s2 [3];
	logic signed [34:0] x1_s2 [3];
	logic signed [34:0] x2_s2 [3];
	logic signed [51:0] pdv_s3 [3];
	logic signed [51:0] pn1_s3 [3];
	logic signed [51:0] pn2_s3 [3];
	logic signed [51:0] pnt_s3 [3];
	logic signed [53:0] dv_s4, n1_s4, n2_s4, nt_s4;
	logic signed [53:0] dv_s5, n1_s5, n2_s5, nt_s5;
	logic               ok;

	assign va[0]  = vertex_a[15:0];
	assign va[1]  = vertex_a[31:16];
	assign va[2]  = vertex_a[47:32];
	assign vb[0]  = vertex_b[15:0];
	assign vb[1]  = vertex_b[31:16];
	assign vb[2]  = vertex_b[47:32];
	assign vc[0]  = vertex_c[15:0];
	assign vc[1]  = vertex_c[31:16];
	assign vc[2]  = vertex_c[47:32];
	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	// credit: every item in the stages or the queue holds one slot
	assign ray_stall = (cnt_q == CNTW'(QD));
	assign acc       = ray_valid && !ray_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_q   <= '0;
		end else begin
			cnt_q <= cnt_q + CNTW'(acc) - CNTW'(pop);
			v_q   <= {v_q[3:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= 17'(vb[i]) - 17'(va[i]);
			e2_s1[i] <= 17'(vc[i]) - 17'(va[i]);
			s_s1[i]  <= 17'(org[i]) - 17'(va[i]);
			d_s1[i]  <= 17'(dir[i]);
		end
		kind_s1 <= ray.kind;
		tmax_s1 <= ray.t_max;

		// s1 = d x e2, s2 = s x e1
		x1_s2[0] <= xd(d_s1[1], e2_s1[2], d_s1[2], e2_s1[1]);
		x1_s2[1] <= xd(d_s1[2], e2_s1[0], d_s1[0], e2_s1[2]);
		x1_s2[2] <= xd(d_s1[0], e2_s1[1], d_s1[1], e2_s1[0]);
		x2_s2[0] <= xd(s_s1[1], e1_s1[2], s_s1[2], e1_s1[1]);
		x2_s2[1] <= xd(s_s1[2], e1_s1[0], s_s1[0], e1_s1[2]);
		x2_s2[2] <= xd(s_s1[0], e1_s1[1], s_s1[1], e1_s1[0]);
		e1_s2   <= e1_s1;
		e2_s2   <= e2_s1;
		s_s2    <= s_s1;
		d_s2    <= d_s1;
		kind_s2 <= kind_s1;
		tmax_s2 <= tmax_s1;

		for (int i = 0; i < 3; i++) begin
			pdv_s3[i] <= mp(x1_s2[i], e1_s2[i]);
			pn1_s3[i] <= mp(x1_s2[i], s_s2[i]);
			pn2_s3[i] <= mp(x2_s2[i], d_s2[i]);
			pnt_s3[i] <= mp(x2_s2[i], e2_s2[i]);
		end
		kind_s3 <= kind_s2;
		tmax_s3 <= tmax_s2;

		dv_s4   <= 54'(pdv_s3[0]) + 54'(pdv_s3[1]) + 54'(pdv_s3[2]);
		n1_s4   <= 54'(pn1_s3[0]) + 54'(pn1_s3[1]) + 54'(pn1_s3[2]);
		n2_s4   <= 54'(pn2_s3[0]) + 54'(pn2_s3[1]) + 54'(pn2_s3[2]);
		nt_s4   <= 54'(pnt_s3[0]) + 54'(pnt_s3[1]) + 54'(pnt_s3[2]);
		kind_s4 <= kind_s3;
		tmax_s4 <= tmax_s3;

		// flip all signs when the divisor is negative
		if (dv_s4 < 0) begin
			dv_s5 <= -dv_s4;
			n1_s5 <= -n1_s4;
			n2_s5 <= -n2_s4;
			nt_s5 <= -nt_s4;
		end else begin
			dv_s5 <= dv_s4;
			n1_s5 <= n1_s4;
			n2_s5 <= n2_s4;
			nt_s5 <= nt_s4;
		end
		kind_s5 <= kind_s4;
		tmax_s5 <= tmax_s4;
	end

	// distance bound nt < 256*dv keeps the quotient within 16 bits
	assign ok = (dv_s5 != '0) && !n1_s5[53] && (n1_s5 <= dv_s5) && !n2_s5[53]
		&& ((55'(n1_s5) + 55'(n2_s5)) <= 55'(dv_s5)) && !nt_s5[53]
		&& (62'(nt_s5) < (62'(dv_s5) <<< 8));

	assign push              = v_q[4];
	assign push_data.kind    = kind_s5;
	assign push_data.t_max   = tmax_s5;
	assign push_data.ok      = ok;
	assign push_data.dv      = dv_s5[MW-1:0];
	assign push_data.n1      = n1_s5[MW-1:0];
	assign push_data.n2      = n2_s5[MW-1:0];
	assign push_data.nt      = nt_s5[NTW-1:0];

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(QD))
		else $error("credit count beyond queue depth");

endmodule

### rtl/rti_queue.sv
// Short queue between front and back parts. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rti_pkg::qctl_t ctl,
	input  rti_pkg::qent_t wdata,
	output logic           nonempty,
	output rti_pkg::qent_t rdata
);
	import rti_pkg::*;

	qent_t           mem [QD];
	logic [QAW-1:0]  wptr_q;
	logic [QAW-1:0]  rptr_q;
	logic [CNTW-1:0] cnt_q;

	assign nonempty = (cnt_q != '0);
	assign rdata    = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.push) wptr_q <= wptr_q + 1'b1;
			if (ctl.pop)  rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + CNTW'(ctl.push) - CNTW'(ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) mem[wptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (cnt_q != CNTW'(QD)) || ctl.pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> nonempty)
		else $error("pop from empty queue");

endmodule

### rtl/rti_back.sv
// Back part: 16-step restoring divider on three lanes, final range test and
// output register. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  rti_pkg::qent_t head,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output rti_pkg::res_t  res
);
	import rti_pkg::*;

	logic        adv;
	logic [16:0] v_s;
	div_t        div_s [17];
	logic        out_v_q;
	res_t        out_q;
	logic        hit;
	logic        full;
	logic [16:0] bsum;

	assign adv       = !out_v_q || !res_stall;
	assign pop       = adv && nonempty;
	assign res_valid = out_v_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s     <= {v_s[15:0], nonempty};
			out_v_q <= v_s[16];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].kind  <= head.kind;
			div_s[0].t_max <= head.t_max;
			div_s[0].ok    <= head.ok;
			div_s[0].dv    <= head.dv;
			div_s[0].r_t   <= RW'(head.nt) << 8;
			div_s[0].r_1   <= RW'(head.n1) << 15;
			div_s[0].r_2   <= RW'(head.n2) << 15;
			div_s[0].q_t   <= '0;
			div_s[0].q_1   <= '0;
			div_s[0].q_2   <= '0;
		end
	end

	for (genvar i = 0; i < 16; i++) begin : g_step
		localparam int K = 15 - i;
		logic [RW-1:0] dk;
		div_t          nx;
		assign dk = RW'(div_s[i].dv) << K;
		always_comb begin
			nx = div_s[i];
			if (div_s[i].r_t >= dk) begin
				nx.r_t    = div_s[i].r_t - dk;
				nx.q_t[K] = 1'b1;
			end
			if (div_s[i].r_1 >= dk) begin
				nx.r_1    = div_s[i].r_1 - dk;
				nx.q_1[K] = 1'b1;
			end
			if (div_s[i].r_2 >= dk) begin
				nx.r_2    = div_s[i].r_2 - dk;
				nx.q_2[K] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) div_s[i+1] <= nx;
		end
	end

	assign hit  = div_s[16].ok && (div_s[16].q_t <= div_s[16].t_max);
	assign full = hit && !div_s[16].kind;
	assign bsum = 17'(div_s[16].q_1) + 17'(div_s[16].q_2);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.hit    <= hit;
			out_q.t_out  <= full ? div_s[16].q_t : div_s[16].t_max;
			out_q.bary_1 <= full ? div_s[16].q_1 : '0;
			out_q.bary_2 <= full ? div_s[16].q_2 : '0;
			out_q.bary_0 <= (full && bsum < ONE_Q15) ? 16'(ONE_Q15 - bsum) : '0;
		end
	end

	a_bary_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[16] && div_s[16].ok) |-> (bsum <= ONE_Q15))
		else $error("barycentric weights exceed one");

endmodule

### rtl/ray_triangle_intersect_top.sv
// Top level of the ray/triangle intersection block: vertex registers, front,
// queue and back. Depends on rti_pkg, rti_front, rti_queue, rti_back.
//
//  channel | signals                        | direction | payload
//  ray     | ray_valid, ray_stall, ray      | in        | ray_t
//  res     | res_valid, res_stall, res      | out       | res_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | vertex write
//
// One ray per cycle sustained while ray_stall stays low. From acceptance a ray passes
// five front stages, the first at the accepting edge, the queue write, the load,
// sixteen divider steps and the output register.
// The front runs freely; a credit count of the queue's eight slots stalls
// ray when every slot is claimed. The back freezes as a whole while a result
// waits under res_stall. Reset clears all valid state and the vertices.
`timescale 1ns / 1ps

module ray_triangle_intersect_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ray_valid,
	output logic          ray_stall,
	input  rti_pkg::ray_t ray,
	output logic          res_valid,
	input  logic          res_stall,
	output rti_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [47:0]   cfg_data
);
	import rti_pkg::*;

	logic [47:0] vertex_a_q;
	logic [47:0] vertex_b_q;
	logic [47:0] vertex_c_q;
	logic        q_push;
	logic        q_pop;
	qctl_t       qctl;
	qent_t       qin;
	qent_t       qout;
	logic        q_nonempty;

	// writes are always taken; an index past the last register is dropped
	assign cfg_ready = 1'b1;

	// gather push from the front and pop from the back for the queue
	assign qctl = '{push: q_push, pop: q_pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q <= '0;
			vertex_b_q <= '0;
			vertex_c_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VERTEX_A: vertex_a_q <= cfg_data;
				REG_VERTEX_B: vertex_b_q <= cfg_data;
				REG_VERTEX_C: vertex_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// geometry and classification, one entry per accepted ray
	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray_valid),
		.ray_stall (ray_stall),
		.ray       (ray),
		.vertex_a  (vertex_a_q),
		.vertex_b  (vertex_b_q),
		.vertex_c  (vertex_c_q),
		.pop       (q_pop),
		.push      (q_push),
		.push_data (qin)
	);

	// decouple the free-running front from the stallable back
	rti_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.wdata    (qin),
		.nonempty (q_nonempty),
		.rdata    (qout)
	);

	// divide, test the distance and format the result
	rti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (q_nonempty),
		.head      (qout),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
